[src/smm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiplier package
// Sizes, codes, types and helper functions shared by the multiplier files.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int MAX_DIM = 4;
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int SIZE_W  = 3;
    localparam int POS_W   = 2;
    localparam int IDX_W   = ($clog2(MAX_DIM) > POS_W) ? $clog2(MAX_DIM) : POS_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PROD_W  = 2 * WORD_W;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] KIND_COMPUTE    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_MULT,
        S_ACCUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
    } mac_ctrl_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } emit_t;

    function automatic logic [IDX_W-1:0] size_last(input logic [SIZE_W-1:0] size);
        logic [IDX_W-1:0] idx;
        if (size == '0)
            idx = '0;
        else if (int'(size) > MAX_DIM)
            idx = IDX_W'(MAX_DIM - 1);
        else
            idx = IDX_W'(size - SIZE_W'(1));
        return idx;
    endfunction

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

[src/smm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

[src/smm_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Shared signed multiplier and wide accumulator with Q16.16 saturation.
// ----------------------------------------------------------------------------
module smm_mac (
    input  wire logic                       clk,
    input  wire smm_pkg::mac_ctrl_t         ctrl,
    input  wire logic [smm_pkg::WORD_W-1:0] a,
    input  wire logic [smm_pkg::WORD_W-1:0] b,
    output logic      [smm_pkg::WORD_W-1:0] result,
    output logic                            sat
);

    localparam int TOP_LO = smm_pkg::FRAC_W + smm_pkg::WORD_W - 1;

    logic signed [smm_pkg::PROD_W-1:0] prod_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_base;
    logic [smm_pkg::ACC_W-1:TOP_LO]    acc_top;
    logic                              pos_ovf;
    logic                              neg_ovf;

    assign acc_base = ctrl.acc_first ? '0 : acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= $signed(a) * $signed(b);
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_base + smm_pkg::ACC_W'(prod_reg);
        end
    end

    assign acc_top = acc_reg[smm_pkg::ACC_W-1:TOP_LO];
    assign pos_ovf = !acc_reg[smm_pkg::ACC_W-1] && (|acc_top);
    assign neg_ovf = acc_reg[smm_pkg::ACC_W-1] && !(&acc_top);

    always_comb
    begin
        sat = pos_ovf || neg_ovf;
        if (pos_ovf)
            result = {1'b0, {(smm_pkg::WORD_W-1){1'b1}}};
        else if (neg_ovf)
            result = {1'b1, {(smm_pkg::WORD_W-1){1'b0}}};
        else
            result = acc_reg[TOP_LO:smm_pkg::FRAC_W];
    end

endmodule
`default_nettype wire

[src/smm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multiplier sequencer
// Walks rows, columns and the inner index, driving reads and the MAC unit.
// ----------------------------------------------------------------------------
module smm_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [smm_pkg::SIZE_W-1:0] size,
    input  wire logic                       out_free,
    output logic                            busy,
    output logic                            rd_en,
    output logic      [smm_pkg::ADDR_W-1:0] left_addr,
    output logic      [smm_pkg::ADDR_W-1:0] right_addr,
    output smm_pkg::mac_ctrl_t              mac,
    output smm_pkg::emit_t                  emit
);

    smm_pkg::state_t state_reg;
    smm_pkg::state_t state_next;

    logic [smm_pkg::IDX_W-1:0] row_reg;
    logic [smm_pkg::IDX_W-1:0] col_reg;
    logic [smm_pkg::IDX_W-1:0] inner_reg;
    logic [smm_pkg::IDX_W-1:0] last_reg;
    logic                      inner_done;
    logic                      final_elem;

    assign inner_done = (inner_reg == last_reg);
    assign final_elem = (row_reg == last_reg) && (col_reg == last_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smm_pkg::S_IDLE:  if (start) state_next = smm_pkg::S_ADDR;
            smm_pkg::S_ADDR:  state_next = smm_pkg::S_MULT;
            smm_pkg::S_MULT:  state_next = smm_pkg::S_ACCUM;
            smm_pkg::S_ACCUM: state_next = inner_done ? smm_pkg::S_EMIT : smm_pkg::S_ADDR;
            smm_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = final_elem ? smm_pkg::S_IDLE : smm_pkg::S_ADDR;
            end
            default:          state_next = smm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy           = (state_reg != smm_pkg::S_IDLE);
        rd_en          = (state_reg == smm_pkg::S_ADDR);
        left_addr      = smm_pkg::mat_addr(row_reg, inner_reg);
        right_addr     = smm_pkg::mat_addr(inner_reg, col_reg);
        mac.mul_en     = (state_reg == smm_pkg::S_MULT);
        mac.acc_en     = (state_reg == smm_pkg::S_ACCUM);
        mac.acc_first  = (inner_reg == '0);
        emit.emit      = (state_reg == smm_pkg::S_EMIT) && out_free;
        emit.last      = final_elem;
        emit.row       = row_reg[smm_pkg::POS_W-1:0];
        emit.col       = col_reg[smm_pkg::POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smm_pkg::S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            inner_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                smm_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        inner_reg <= '0;
                        last_reg  <= smm_pkg::size_last(size);
                    end
                end
                smm_pkg::S_ACCUM:
                begin
                    if (!inner_done)
                        inner_reg <= inner_reg + smm_pkg::IDX_W'(1);
                end
                smm_pkg::S_EMIT:
                begin
                    if (out_free && !final_elem)
                    begin
                        inner_reg <= '0;
                        if (col_reg == last_reg)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + smm_pkg::IDX_W'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + smm_pkg::IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/square_matrix_multiply.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiplier
// Loads two square Q16.16 matrices and streams their saturated product.
// ----------------------------------------------------------------------------
// The input channel carries one word per item. A load word writes one element
// of the left or right matrix and leaves the input free for the next word. A
// compute word streams the n by n product in row-major order on the output
// channel, with last set on the final element, and stalls the input until the
// final element is handed to the output register. Per element, the shared
// multiplier and accumulator do read, multiply and accumulate per inner step,
// then hand the element to the output register. A stall on the output holds
// the current element in the output register; the sequencer waits with the
// next element until the word is taken, and the next word may be accepted
// while the final element still waits. The user must write the configured
// size only while idle; the block does not enforce this. Reset returns the
// size to the maximum and empties the output register; the matrix memories
// are not cleared and must be loaded before they are used.
// ----------------------------------------------------------------------------
module square_matrix_multiply (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [smm_pkg::SIZE_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 kind,
    input  wire logic [smm_pkg::POS_W-1:0]  row_index,
    input  wire logic [smm_pkg::POS_W-1:0]  col_index,
    input  wire logic [smm_pkg::WORD_W-1:0] element_value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [smm_pkg::POS_W-1:0]  out_row,
    output logic      [smm_pkg::POS_W-1:0]  out_col,
    output logic      [smm_pkg::WORD_W-1:0] product_value,
    output logic                            saturated,
    output logic                            last
);

    logic [smm_pkg::SIZE_W-1:0] size_reg;
    logic                       in_accept;
    logic                       load_ok;
    logic                       wr_left;
    logic                       wr_right;
    logic [smm_pkg::ADDR_W-1:0] wr_addr;
    logic                       start;
    logic                       out_free;
    logic                       busy;
    logic                       rd_en;
    logic [smm_pkg::ADDR_W-1:0] left_addr;
    logic [smm_pkg::ADDR_W-1:0] right_addr;
    logic [smm_pkg::WORD_W-1:0] left_data;
    logic [smm_pkg::WORD_W-1:0] right_data;
    logic [smm_pkg::WORD_W-1:0] mac_result;
    logic                       mac_sat;
    smm_pkg::mac_ctrl_t         mac;
    smm_pkg::emit_t             emit;

    logic                       out_valid_reg;
    logic [smm_pkg::POS_W-1:0]  out_row_reg;
    logic [smm_pkg::POS_W-1:0]  out_col_reg;
    logic [smm_pkg::WORD_W-1:0] product_reg;
    logic                       sat_reg;
    logic                       last_reg;

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign load_ok   = (int'(row_index) < smm_pkg::MAX_DIM)
                    && (int'(col_index) < smm_pkg::MAX_DIM);
    assign wr_left   = in_accept && (kind == smm_pkg::KIND_LOAD_LEFT) && load_ok;
    assign wr_right  = in_accept && (kind == smm_pkg::KIND_LOAD_RIGHT) && load_ok;
    assign wr_addr   = smm_pkg::mat_addr(smm_pkg::IDX_W'(row_index),
                                         smm_pkg::IDX_W'(col_index));
    assign start     = in_accept && (kind == smm_pkg::KIND_COMPUTE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= smm_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    smm_ram #(
        .WIDTH (smm_pkg::WORD_W),
        .DEPTH (smm_pkg::DEPTH)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (wr_left),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    smm_ram #(
        .WIDTH (smm_pkg::WORD_W),
        .DEPTH (smm_pkg::DEPTH)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (wr_right),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    smm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .size       (size_reg),
        .out_free   (out_free),
        .busy       (busy),
        .rd_en      (rd_en),
        .left_addr  (left_addr),
        .right_addr (right_addr),
        .mac        (mac),
        .emit       (emit)
    );

    smm_mac u_mac (
        .clk    (clk),
        .ctrl   (mac),
        .a      (left_data),
        .b      (right_data),
        .result (mac_result),
        .sat    (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.emit)
        begin
            out_row_reg <= emit.row;
            out_col_reg <= emit.col;
            product_reg <= mac_result;
            sat_reg     <= mac_sat;
            last_reg    <= emit.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = product_reg;
    assign saturated     = sat_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

[src/smm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Square matrix multiplier checker
// Port-level properties of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module smm_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cfg_wr_en,
    input wire logic [smm_pkg::SIZE_W-1:0] cfg_wr_data,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic [1:0]                 kind,
    input wire logic [smm_pkg::POS_W-1:0]  row_index,
    input wire logic [smm_pkg::POS_W-1:0]  col_index,
    input wire logic [smm_pkg::WORD_W-1:0] element_value,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [smm_pkg::POS_W-1:0]  out_row,
    input wire logic [smm_pkg::POS_W-1:0]  out_col,
    input wire logic [smm_pkg::WORD_W-1:0] product_value,
    input wire logic                       saturated,
    input wire logic                       last
);

    logic in_take;
    logic out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_value) && $stable(last))
        else $error("stalled output word changed");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (kind == smm_pkg::KIND_COMPUTE) |=> in_stall)
        else $error("compute word did not stall the input");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && ((kind == smm_pkg::KIND_LOAD_LEFT) || (kind == smm_pkg::KIND_LOAD_RIGHT))
        |=> !in_stall)
        else $error("load word held the input");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({cfg_wr_en, in_valid, in_stall, out_valid, out_stall, out_take})
        && (!cfg_wr_en || !$isunknown(cfg_wr_data))
        && (!in_valid || !$isunknown({kind, row_index, col_index, element_value}))
        && (!out_valid || !$isunknown({out_row, out_col, product_value, saturated, last})))
        else $error("unknown value on a handshake or a valid word");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (.*);
`default_nettype wire

[tb/square_matrix_multiply_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Square matrix multiplier testbench
// Loads left and right Q16.16 matrices word by word, requests products over a
// series of size settings, and compares each streamed element with a local
// prediction of the saturated, floor-rounded dot product.
// ----------------------------------------------------------------------------
module square_matrix_multiply_test;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         RANDOM_WORDS  = 280;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         IDLE_PERCENT  = 11;
    localparam int         REPORT_LIMIT  = 10;

    localparam logic signed [67:0] Q_MAX = 68'sd2147483647;
    localparam logic signed [67:0] Q_MIN = -68'sd2147483648;

    typedef enum logic {
        STEP_SIZE,
        STEP_WORD
    } step_kind_t;

    typedef struct packed {
        step_kind_t       step;
        logic [2:0]       size;
        logic [1:0]       word_kind;
        logic [1:0]       row;
        logic [1:0]       col;
        logic [31:0]      value;
        logic             typed;
        logic [31:0]      want_value;
        logic             want_sat;
    } directed_row_t;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        sat;
        logic        last;
    } product_word_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{STEP_SIZE, 3'd1, KIND_UNUSED,     2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h7FFF_FFFF,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, 1'b1},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h8000_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'h8000_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF, 1'b1},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'h8000_0000, 1'b1},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h0001_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'h0001_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'h0001_0000, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h0000_0001,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'hFFFF_FFFF,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_WORD, 3'd0, KIND_UNUSED,     2'd3, 2'd3, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd3, 2'd3, 32'hFFFF_FFFF,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_RIGHT, 2'd3, 2'd2, 32'h8000_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_SIZE, 3'd0, KIND_UNUSED,     2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h0000_0000,
          1'b0, 32'h0, 1'b0},
        '{STEP_WORD, 3'd0, smm_pkg::KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000,
          1'b1, 32'h0000_0000, 1'b0}
    };

    localparam logic [2:0] SIZE_ORDER [8] = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6};

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [smm_pkg::SIZE_W-1:0]   cfg_wr_data   = '0;
    logic                         in_valid      = 1'b0;
    logic                         in_stall;
    logic [1:0]                   kind          = '0;
    logic [smm_pkg::POS_W-1:0]    row_index     = '0;
    logic [smm_pkg::POS_W-1:0]    col_index     = '0;
    logic [smm_pkg::WORD_W-1:0]   element_value = '0;
    logic                         out_valid;
    logic                         out_stall     = 1'b0;
    logic [smm_pkg::POS_W-1:0]    out_row;
    logic [smm_pkg::POS_W-1:0]    out_col;
    logic [smm_pkg::WORD_W-1:0]   product_value;
    logic                         saturated;
    logic                         last;

    logic signed [31:0]  left_mat   [smm_pkg::MAX_DIM][smm_pkg::MAX_DIM];
    logic signed [31:0]  right_mat  [smm_pkg::MAX_DIM][smm_pkg::MAX_DIM];
    bit                  left_known [smm_pkg::MAX_DIM][smm_pkg::MAX_DIM];
    bit                  right_known[smm_pkg::MAX_DIM][smm_pkg::MAX_DIM];
    logic [smm_pkg::SIZE_W-1:0] size_setting = smm_pkg::SIZE_RESET;
    bit   [7:0]          sizes_used   = '0;

    product_word_t       expected_products[$];
    bit                  quiet          = 1'b0;
    int                  words_sent     = 0;
    int                  computes_sent  = 0;
    int                  products_seen  = 0;
    int                  error_count    = 0;
    int                  cycle_count    = 0;

    square_matrix_multiply DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .saturated     (saturated),
        .last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int effective_size(input logic [smm_pkg::SIZE_W-1:0] setting);
        if (setting == '0)
            return 1;
        if (int'(setting) > smm_pkg::MAX_DIM)
            return smm_pkg::MAX_DIM;
        return int'(setting);
    endfunction

    function automatic void predict_products();
        int                 n;
        logic signed [67:0] acc;
        logic signed [67:0] scaled;
        product_word_t      w;
        n = effective_size(size_setting);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                acc = '0;
                for (int i = 0; i < n; i++)
                    acc = acc + left_mat[r][i] * right_mat[i][c];
                scaled = acc >>> smm_pkg::FRAC_W;
                w.sat = 1'b0;
                if (scaled > Q_MAX)
                begin
                    scaled = Q_MAX;
                    w.sat  = 1'b1;
                end
                else if (scaled < Q_MIN)
                begin
                    scaled = Q_MIN;
                    w.sat  = 1'b1;
                end
                w.row   = 2'(r);
                w.col   = 2'(c);
                w.value = scaled[31:0];
                w.last  = (r == n - 1) && (c == n - 1);
                expected_products.push_back(w);
            end
        end
    endfunction

    function automatic void check_product();
        product_word_t w;
        products_seen++;
        if (expected_products.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("Unexpected product word: row %0d col %0d value %h sat %b last %b",
                         out_row, out_col, product_value, saturated, last);
            return;
        end
        w = expected_products.pop_front();
        if (out_row !== w.row || out_col !== w.col || product_value !== w.value ||
            saturated !== w.sat || last !== w.last)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("Product mismatch: expected row %0d col %0d value %h sat %b last %b",
                         w.row, w.col, w.value, w.sat, w.last);
                $display("                  got      row %0d col %0d value %h sat %b last %b",
                         out_row, out_col, product_value, saturated, last);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_product();
            out_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PERCENT);
        end
    end

    function automatic logic [31:0] random_element();
        logic [18:0] small_bits;
        small_bits = 19'($urandom);
        case ($urandom_range(9, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3, 4, 5, 6: return {{13{small_bits[18]}}, small_bits};
            default: return $urandom;
        endcase
    endfunction

    task automatic write_size(input logic [smm_pkg::SIZE_W-1:0] setting);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        size_setting = setting;
        sizes_used[setting] = 1'b1;
    endtask

    task automatic send_word(input logic [1:0] word_kind, input logic [1:0] row,
                             input logic [1:0] col, input logic [31:0] value,
                             input logic typed, input logic [31:0] want_value,
                             input logic want_sat);
        product_word_t w;
        while (!quiet && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= word_kind;
        row_index     <= row;
        col_index     <= col;
        element_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        case (word_kind)
            smm_pkg::KIND_LOAD_LEFT:
            begin
                left_mat[row][col]   = value;
                left_known[row][col] = 1'b1;
            end
            smm_pkg::KIND_LOAD_RIGHT:
            begin
                right_mat[row][col]   = value;
                right_known[row][col] = 1'b1;
            end
            smm_pkg::KIND_COMPUTE:
            begin
                computes_sent++;
                if (typed)
                begin
                    w.row   = 2'd0;
                    w.col   = 2'd0;
                    w.value = want_value;
                    w.sat   = want_sat;
                    w.last  = 1'b1;
                    expected_products.push_back(w);
                end
                else
                    predict_products();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_noise();
        if ($urandom_range(1, 0) == 0)
            send_word(KIND_UNUSED, 2'($urandom), 2'($urandom), $urandom, 1'b0, '0, 1'b0);
        else
            send_word(2'($urandom_range(1, 0)), 2'($urandom), 2'($urandom),
                      random_element(), 1'b0, '0, 1'b0);
    endtask

    initial
    begin
        directed_row_t d;
        logic [2:0]    setting;
        int            n;
        int            set_index;
        int            pick;
        int            slot;
        int            slots[$];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            d = DIRECTED[k];
            if (d.step == STEP_SIZE)
                write_size(d.size);
            else
                send_word(d.word_kind, d.row, d.col, d.value, d.typed, d.want_value,
                          d.want_sat);
        end

        set_index = 0;
        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS)
        begin
            setting = (set_index < 8) ? SIZE_ORDER[set_index] : 3'($urandom_range(7, 0));
            quiet = 1'b0;
            write_size(setting);
            quiet = (set_index == 5);
            n = effective_size(setting);
            repeat ($urandom_range(3, 1))
            begin
                slots.delete();
                for (int m = 0; m < 2; m++)
                    for (int r = 0; r < n; r++)
                        for (int c = 0; c < n; c++)
                        begin
                            if ((m == 0 && !left_known[r][c]) ||
                                (m == 1 && !right_known[r][c]) ||
                                $urandom_range(99, 0) < 85)
                                slots.push_back(m * 16 + r * 4 + c);
                        end
                for (int k = slots.size() - 1; k > 0; k--)
                begin
                    pick        = $urandom_range(k, 0);
                    slot        = slots[k];
                    slots[k]    = slots[pick];
                    slots[pick] = slot;
                end
                foreach (slots[k])
                begin
                    if ($urandom_range(99, 0) < 10)
                        send_noise();
                    slot = slots[k];
                    send_word((slot >= 16) ? smm_pkg::KIND_LOAD_RIGHT : smm_pkg::KIND_LOAD_LEFT,
                              2'((slot % 16) / 4), 2'(slot % 4), random_element(),
                              1'b0, '0, 1'b0);
                end
                send_word(smm_pkg::KIND_COMPUTE, 2'($urandom), 2'($urandom), $urandom,
                          1'b0, '0, 1'b0);
            end
            set_index++;
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (5 * SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words including %0d product requests over %0d size settings",
                 words_sent, computes_sent, set_index + 2);
        $display("Checked %0d product elements; size codes used %b; %0d errors",
                 products_seen, sizes_used, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
